// File: design/ldu_pkg.sv
// Package for the lens undistortion remap unit: payload structs, register
// indexes, reset values and size defaults. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ldu_pkg;

  // Default frame size.
  localparam int IMG_COLS_DEF = 1024;
  localparam int IMG_ROWS_DEF = 512;

  // Field widths.
  localparam int COL_W      = 10;
  localparam int ROW_W      = 9;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Command codes.
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TANGENTIAL_P1 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TANGENTIAL_P2 = 3'd7;

  // Register reset values.
  localparam logic [23:0] RST_FOCAL_X  = 24'd1878647;
  localparam logic [23:0] RST_FOCAL_Y  = 24'd1873084;
  localparam logic [23:0] RST_CENTER_X = 24'd1504113;
  localparam logic [23:0] RST_CENTER_Y = 24'd1017344;
  localparam logic [31:0] RST_K1 = -32'sd76076785;
  localparam logic [31:0] RST_K2 = 32'd19853237;
  localparam logic [31:0] RST_P1 = 32'd51966;
  localparam logic [31:0] RST_P2 = 32'd4729;

  // Input request.
  typedef struct packed {
    logic             command;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] pixel;
  } req_t;

  // Result.
  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             in_range;
  } rsp_t;

endpackage

`default_nettype wire

// File: design/lens_undistort_bilinear_remap_unit.sv
// Lens undistortion remap unit: radial and tangential model with bilinear
// sampling out of a four-bank frame store. Depends on ldu_pkg.
// Throughput: one request per cycle while no result is held in the output
// register; one divider step per stage sets the depth.
// Write requests take the same path and write the frame store in stage 41.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the
// register defaults; the frame store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module lens_undistort_bilinear_remap_unit #(
  parameter int IMG_COLS = ldu_pkg::IMG_COLS_DEF,
  parameter int IMG_ROWS = ldu_pkg::IMG_ROWS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  ldu_pkg::req_t                    in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output ldu_pkg::rsp_t                    out_rsp_o,
  input  logic                             cfg_we_i,
  input  logic [ldu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ldu_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import ldu_pkg::*;

  localparam int NSB   = 44;
  localparam int SB_WR = 41;
  localparam int QW    = 27;
  localparam int CW    = $clog2(IMG_COLS);
  localparam int RW    = $clog2(IMG_ROWS);
  localparam int CHW   = ((IMG_COLS + 1) / 2 > 1) ? $clog2((IMG_COLS + 1) / 2) : 1;
  localparam int RHW   = ((IMG_ROWS + 1) / 2 > 1) ? $clog2((IMG_ROWS + 1) / 2) : 1;
  localparam int BAW   = CHW + RHW;
  localparam int BDEPTH = 1 << BAW;
  localparam logic signed [39:0] U_LIM = 40'(IMG_COLS * 4096);
  localparam logic signed [39:0] V_LIM = 40'(IMG_ROWS * 4096);
  localparam logic signed [39:0] F_HI  = 40'sh0080000000;
  localparam logic signed [39:0] F_LO  = -40'sh0080000000;
  localparam logic [QW-1:0] Q_MAX = 27'h4000000;

  typedef struct packed {
    logic             valid;
    logic             cmd;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] pix;
  } sb_t;

  typedef struct packed {
    logic [23:0]   rem;
    logic [QW-1:0] quo;
    logic [2:0]    dvd;
    logic          ovf;
    logic          neg;
  } dv_t;

  // One restoring division step: bring down a dividend bit, subtract if it fits.
  function automatic dv_t div_step(dv_t a, logic [23:0] d);
    dv_t         r;
    logic [24:0] t;
    logic        ge;
    t  = {a.rem, a.dvd[2]};
    ge = (t >= {1'b0, d});
    r  = a;
    r.rem = ge ? 24'(t - {1'b0, d}) : t[23:0];
    r.quo = {a.quo[QW-2:0], ge};
    r.dvd = {a.dvd[1:0], 1'b0};
    return r;
  endfunction

  // Configuration registers.
  logic [23:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [31:0] k1_q, k2_q, p1_q, p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= RST_FOCAL_X;
      focal_y_q  <= RST_FOCAL_Y;
      center_x_q <= RST_CENTER_X;
      center_y_q <= RST_CENTER_Y;
      k1_q       <= RST_K1;
      k2_q       <= RST_K2;
      p1_q       <= RST_P1;
      p2_q       <= RST_P2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FOCAL_X:       focal_x_q  <= cfg_wdata_i[23:0];
        REG_FOCAL_Y:       focal_y_q  <= cfg_wdata_i[23:0];
        REG_CENTER_X:      center_x_q <= cfg_wdata_i[23:0];
        REG_CENTER_Y:      center_y_q <= cfg_wdata_i[23:0];
        REG_RADIAL_K1:     k1_q       <= cfg_wdata_i;
        REG_RADIAL_K2:     k2_q       <= cfg_wdata_i;
        REG_TANGENTIAL_P1: p1_q       <= cfg_wdata_i;
        REG_TANGENTIAL_P2: p2_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A zero focal length counts as one LSB.
  logic [23:0] fxe, fye;
  assign fxe = (focal_x_q == '0) ? 24'd1 : focal_x_q;
  assign fye = (focal_y_q == '0) ? 24'd1 : focal_y_q;

  // The whole pipeline moves together; the output register decides.
  logic adv;
  logic out_valid_q;
  rsp_t out_rsp_q;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Request sideband travels with the data down to the blend stage.
  sb_t sb_q [NSB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSB; i++) sb_q[i] <= '0;
    end else if (adv) begin
      sb_q[0] <= {in_valid_i, in_req_i.command, in_req_i.col, in_req_i.row,
                  in_req_i.pixel};
      for (int i = 1; i < NSB; i++) sb_q[i] <= sb_q[i-1];
    end
  end

  // Stages 1 to 3: numerator, magnitude, overflow check and divider setup.
  logic signed [25:0] num_x_q, num_y_q;
  logic [24:0]        mag_x_q, mag_y_q;
  logic               neg_x_q, neg_y_q;
  dv_t                dvx_q [QW+1];
  dv_t                dvy_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_x_q <= $signed({4'b0, sb_q[0].col, 12'b0}) - $signed({2'b0, center_x_q});
      num_y_q <= $signed({5'b0, sb_q[0].row, 12'b0}) - $signed({2'b0, center_y_q});
      neg_x_q <= num_x_q[25];
      neg_y_q <= num_y_q[25];
      mag_x_q <= 25'(num_x_q[25] ? -num_x_q : num_x_q);
      mag_y_q <= 25'(num_y_q[25] ? -num_y_q : num_y_q);
      dvx_q[0] <= '{rem: 24'(mag_x_q >> 3), quo: '0, dvd: mag_x_q[2:0],
                    ovf: ({2'b0, mag_x_q} >= {fxe, 3'b0}), neg: neg_x_q};
      dvy_q[0] <= '{rem: 24'(mag_y_q >> 3), quo: '0, dvd: mag_y_q[2:0],
                    ovf: ({2'b0, mag_y_q} >= {fye, 3'b0}), neg: neg_y_q};
    end
  end

  // Stages 4 to 30: one quotient bit per stage.
  for (genvar j = 0; j < QW; j++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dvx_q[j+1] <= div_step(dvx_q[j], fxe);
        dvy_q[j+1] <= div_step(dvy_q[j], fye);
      end
    end
  end

  // Stage 31: saturate to four and apply the sign.
  logic [QW-1:0]      qx_m, qy_m;
  logic signed [27:0] x_q [6];
  logic signed [27:0] y_q [6];
  assign qx_m = (dvx_q[QW].ovf || dvx_q[QW].quo > Q_MAX) ? Q_MAX : dvx_q[QW].quo;
  assign qy_m = (dvy_q[QW].ovf || dvy_q[QW].quo > Q_MAX) ? Q_MAX : dvy_q[QW].quo;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0] <= dvx_q[QW].neg ? -$signed({1'b0, qx_m}) : $signed({1'b0, qx_m});
      y_q[0] <= dvy_q[QW].neg ? -$signed({1'b0, qy_m}) : $signed({1'b0, qy_m});
      for (int i = 1; i < 6; i++) begin
        x_q[i] <= x_q[i-1];
        y_q[i] <= y_q[i-1];
      end
    end
  end

  // Stage 32: squares and cross product.
  logic signed [55:0] xx_p, yy_p, xy_p;
  logic signed [29:0] x2_q, y2_q, xy_q, xyb_q;
  assign xx_p = x_q[0] * x_q[0];
  assign yy_p = y_q[0] * y_q[0];
  assign xy_p = x_q[0] * y_q[0];

  // Stage 33: r squared and the tangential sums.
  logic signed [30:0] r2_q, r2b_q;
  logic signed [31:0] tx_q, ty_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x2_q  <= xx_p[53:24];
      y2_q  <= yy_p[53:24];
      xy_q  <= xy_p[53:24];
      xyb_q <= xy_q;
      r2_q  <= 31'(x2_q) + 31'(y2_q);
      tx_q  <= (32'(x2_q) <<< 1) + 32'(x2_q) + 32'(y2_q);
      ty_q  <= (32'(y2_q) <<< 1) + 32'(y2_q) + 32'(x2_q);
      r2b_q <= r2_q;
    end
  end

  // Stage 34: coefficient products.
  logic signed [62:0] a1_p, a2_p;
  logic signed [61:0] px_p, py_p;
  logic signed [63:0] tpx_p, tpy_p;
  logic signed [34:0] a1_q, a1b_q, a2_q;
  logic signed [33:0] px_q, py_q;
  logic signed [35:0] tpx_q, tpy_q;
  assign a1_p  = $signed(k1_q) * r2_q;
  assign a2_p  = $signed(k2_q) * r2_q;
  assign px_p  = $signed(p1_q) * xyb_q;
  assign py_p  = $signed(p2_q) * xyb_q;
  assign tpx_p = $signed(p2_q) * tx_q;
  assign tpy_p = $signed(p1_q) * ty_q;

  // Stage 35: second radial term and tangential offsets.
  logic signed [65:0] b2_p;
  logic signed [38:0] b2_q;
  logic signed [36:0] tanx_q [3];
  logic signed [36:0] tany_q [3];
  assign b2_p = a2_q * r2b_q;

  // Stage 36: radial factor with saturation.
  logic signed [39:0] f_s;
  logic signed [32:0] f_q;
  assign f_s = 40'sh0001000000 + 40'(a1b_q) + 40'(b2_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_q  <= a1_p[62:28];
      a2_q  <= a2_p[62:28];
      px_q  <= px_p[61:28];
      py_q  <= py_p[61:28];
      tpx_q <= tpx_p[63:28];
      tpy_q <= tpy_p[63:28];
      b2_q  <= b2_p[62:24];
      a1b_q <= a1_q;
      tanx_q[0] <= (37'(px_q) <<< 1) + 37'(tpx_q);
      tany_q[0] <= 37'(tpy_q) + (37'(py_q) <<< 1);
      tanx_q[1] <= tanx_q[0];
      tany_q[1] <= tany_q[0];
      tanx_q[2] <= tanx_q[1];
      tany_q[2] <= tany_q[1];
      if (f_s > F_HI) begin
        f_q <= 33'(F_HI);
      end else if (f_s < F_LO) begin
        f_q <= 33'(F_LO);
      end else begin
        f_q <= 33'(f_s);
      end
    end
  end

  // Stages 37 to 40: distorted point back in pixel units.
  logic signed [60:0] xf_p, yf_p;
  logic signed [36:0] xf_q, yf_q;
  logic signed [37:0] xd_q, yd_q;
  logic signed [62:0] pu_p, pv_p;
  logic signed [38:0] pu_q, pv_q;
  logic signed [39:0] ud_q, vd_q;
  assign xf_p = x_q[5] * f_q;
  assign yf_p = y_q[5] * f_q;
  assign pu_p = $signed({1'b0, fxe}) * xd_q;
  assign pv_p = $signed({1'b0, fye}) * yd_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xf_q <= xf_p[60:24];
      yf_q <= yf_p[60:24];
      xd_q <= 38'(xf_q) + 38'(tanx_q[2]);
      yd_q <= 38'(yf_q) + 38'(tany_q[2]);
      pu_q <= pu_p[62:24];
      pv_q <= pv_p[62:24];
      ud_q <= 40'(pu_q) + $signed({16'b0, center_x_q});
      vd_q <= 40'(pv_q) + $signed({16'b0, center_y_q});
    end
  end

  // Stage 41: range checks, integer and fractional parts.
  logic          bad_q, bad2_q, bad3_q;
  logic [CW-1:0] iu_q;
  logic [RW-1:0] iv_q;
  logic [11:0]   fu_q, fv_q, fu2_q, fv2_q, fv3_q;
  logic          cpar_q, rpar_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bad_q <= ud_q[39] || vd_q[39] || (ud_q >= U_LIM) || (vd_q >= V_LIM)
               || (32'(ud_q[12 +: CW]) > 32'(IMG_COLS - 2))
               || (32'(vd_q[12 +: RW]) > 32'(IMG_ROWS - 2));
      iu_q  <= ud_q[12 +: CW];
      iv_q  <= vd_q[12 +: RW];
      fu_q  <= ud_q[11:0];
      fv_q  <= vd_q[11:0];
      bad2_q <= bad_q;
      fu2_q  <= fu_q;
      fv2_q  <= fv_q;
      cpar_q <= iu_q[0];
      rpar_q <= iv_q[0];
    end
  end

  // Frame store: four banks by column and row parity, so a 2x2 window
  // reads each bank once. Write requests land here in request order.
  logic [CW:0]    iu_inc;
  logic [RW:0]    iv_inc;
  logic [CHW-1:0] col_even, col_odd, wr_col;
  logic [RHW-1:0] row_even, row_odd, wr_row;
  logic           wr_ok;
  logic [7:0]     bank_rd [4];

  assign iu_inc   = {1'b0, iu_q} + {{CW{1'b0}}, 1'b1};
  assign iv_inc   = {1'b0, iv_q} + {{RW{1'b0}}, 1'b1};
  assign col_even = CHW'(iu_inc >> 1);
  assign col_odd  = CHW'(iu_q >> 1);
  assign row_even = RHW'(iv_inc >> 1);
  assign row_odd  = RHW'(iv_q >> 1);
  assign wr_col   = CHW'(sb_q[SB_WR].col >> 1);
  assign wr_row   = RHW'(sb_q[SB_WR].row >> 1);
  assign wr_ok    = adv && sb_q[SB_WR].valid && (sb_q[SB_WR].cmd == CMD_WRITE)
                    && (32'(sb_q[SB_WR].col) < 32'(IMG_COLS))
                    && (32'(sb_q[SB_WR].row) < 32'(IMG_ROWS));

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic CP = 1'(b % 2);
    localparam logic RP = 1'(b / 2);
    logic [7:0]     mem [BDEPTH];
    logic [7:0]     rd_q;
    logic [BAW-1:0] ra;
    logic           we;
    assign ra = {(RP ? row_odd : row_even), (CP ? col_odd : col_even)};
    assign we = wr_ok && (sb_q[SB_WR].col[0] == CP) && (sb_q[SB_WR].row[0] == RP);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (we) begin
          mem[{wr_row, wr_col}] <= sb_q[SB_WR].pix;
        end
        rd_q <= mem[ra];
      end
    end
    assign bank_rd[b] = rd_q;
  end

  // Stage 43: horizontal blends of the top and bottom rows.
  logic [7:0]  lt, rt, lb, rb, top_q, bot_q;
  logic [12:0] wu, wv;
  logic [20:0] top_s, bot_s, val_s;
  assign lt    = bank_rd[{rpar_q, cpar_q}];
  assign rt    = bank_rd[{rpar_q, !cpar_q}];
  assign lb    = bank_rd[{!rpar_q, cpar_q}];
  assign rb    = bank_rd[{!rpar_q, !cpar_q}];
  assign wu    = 13'd4096 - {1'b0, fu2_q};
  assign top_s = 21'(fu2_q) * 21'(rt) + 21'(wu) * 21'(lt);
  assign bot_s = 21'(fu2_q) * 21'(rb) + 21'(wu) * 21'(lb);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      top_q  <= top_s[19:12];
      bot_q  <= bot_s[19:12];
      bad3_q <= bad2_q;
      fv3_q  <= fv2_q;
    end
  end

  // Stage 44: vertical blend into the result register.
  assign wv    = 13'd4096 - {1'b0, fv3_q};
  assign val_s = 21'(top_q) * 21'(wv) + 21'(bot_q) * 21'(fv3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sb_q[NSB-1].valid && (sb_q[NSB-1].cmd == CMD_COMPUTE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_rsp_q.value    <= bad3_q ? '0 : val_s[19:12];
      out_rsp_q.in_range <= !bad3_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // A held result stops the intake.
  a_hold_stops_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("request taken while a result is held");

  // A result outside the image carries a zero value.
  a_zero_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.in_range |-> out_rsp_o.value == '0)
    else $error("out-of-range result with nonzero value");

  // A write request never yields a result.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && sb_q[NSB-1].valid && (sb_q[NSB-1].cmd == CMD_WRITE) |=> !out_valid_q)
    else $error("write request produced a result");

  // A stall freezes the last pipeline stage.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(sb_q[NSB-1]))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// File: sim/lens_undistort_bilinear_remap_unit_tb.sv
// Self-checking testbench for the lens undistortion remap unit: drives write and
// compute requests, predicts every result in fixed point and checks it.
// Depends on ldu_pkg and lens_undistort_bilinear_remap_unit.
`timescale 1ns / 1ps

module lens_undistort_bilinear_remap_unit_tb;
  import ldu_pkg::*;

  localparam int NCOLS = IMG_COLS_DEF;
  localparam int NROWS = IMG_ROWS_DEF;
  localparam int PIPE_DRAIN = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_rsp_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  lens_undistort_bilinear_remap_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .out_valid_o, .out_ready_i, .out_rsp_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always #6 clk_i = ~clk_i;

  // Shadow state of the block: registers and frame store.
  logic [31:0] remap_regs [0:7];
  bit [7:0] shadow_frame [0:NCOLS*NROWS-1];
  bit shadow_written [0:NCOLS*NROWS-1];

  req_t pending_reqs[$];
  rsp_t expected_pixels[$];
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int err_count = 0;
  int n_writes = 0;
  int n_computes = 0;
  int n_inside = 0;
  int n_checked = 0;
  bit hold_arm = 0;
  bit hold_used = 0;
  int hold_cnt = 0;

  // Normalize one coordinate to Q24, saturated to plus or minus four.
  function automatic longint normalize_q24(longint pos, longint center, longint focal);
    longint num, q;
    num = pos * 4096 - center;
    q = (num * (64'sd1 <<< 24)) / focal;
    if (q < -(64'sd1 <<< 26)) q = -(64'sd1 <<< 26);
    if (q > (64'sd1 <<< 26)) q = 64'sd1 <<< 26;
    return q;
  endfunction

  // Map an output pixel to its distorted source point in Q12 pixel units.
  function automatic void distort_point(input int c, input int r,
                                        output longint ud, output longint vd);
    longint fx, fy, k1, k2, p1, p2, x, y, x2, y2, xy, r2, f, xd, yd;
    fx = longint'(remap_regs[REG_FOCAL_X][23:0]);
    fy = longint'(remap_regs[REG_FOCAL_Y][23:0]);
    if (fx == 0) fx = 1;
    if (fy == 0) fy = 1;
    k1 = longint'($signed(remap_regs[REG_RADIAL_K1]));
    k2 = longint'($signed(remap_regs[REG_RADIAL_K2]));
    p1 = longint'($signed(remap_regs[REG_TANGENTIAL_P1]));
    p2 = longint'($signed(remap_regs[REG_TANGENTIAL_P2]));
    x = normalize_q24(longint'(c), longint'(remap_regs[REG_CENTER_X][23:0]), fx);
    y = normalize_q24(longint'(r), longint'(remap_regs[REG_CENTER_Y][23:0]), fy);
    x2 = (x * x) >>> 24;
    y2 = (y * y) >>> 24;
    xy = (x * y) >>> 24;
    r2 = x2 + y2;
    f = (64'sd1 <<< 24) + ((k1 * r2) >>> 28) + ((((k2 * r2) >>> 28) * r2) >>> 24);
    if (f < -(64'sd1 <<< 31)) f = -(64'sd1 <<< 31);
    if (f > (64'sd1 <<< 31)) f = 64'sd1 <<< 31;
    xd = ((x * f) >>> 24) + 2 * ((p1 * xy) >>> 28) + ((p2 * (r2 + 2 * x2)) >>> 28);
    yd = ((y * f) >>> 24) + ((p1 * (r2 + 2 * y2)) >>> 28) + 2 * ((p2 * xy) >>> 28);
    ud = ((fx * xd) >>> 24) + longint'(remap_regs[REG_CENTER_X][23:0]);
    vd = ((fy * yd) >>> 24) + longint'(remap_regs[REG_CENTER_Y][23:0]);
  endfunction

  task automatic add_write(input int c, input int r, input int p);
    req_t q;
    q.command = CMD_WRITE;
    q.col = COL_W'(c);
    q.row = ROW_W'(r);
    q.pixel = PIX_W'(p);
    pending_reqs.push_back(q);
    shadow_frame[r * NCOLS + c] = PIX_W'(p);
    shadow_written[r * NCOLS + c] = 1;
    n_writes++;
  endtask

  // Queue a compute; any unwritten pixel of its sample window is written first.
  task automatic add_compute(input int c, input int r);
    longint ud, vd, iu, iv, fu, fv, lt, rt, lb, rb, top, bot;
    int base;
    req_t q;
    rsp_t e;
    distort_point(c, r, ud, vd);
    e = '0;
    if (ud >= 0 && vd >= 0 && ud < (longint'(NCOLS) <<< 12) && vd < (longint'(NROWS) <<< 12)
        && (ud >>> 12) <= NCOLS - 2 && (vd >>> 12) <= NROWS - 2) begin
      iu = ud >>> 12;
      iv = vd >>> 12;
      fu = ud & 12'hFFF;
      fv = vd & 12'hFFF;
      base = int'(iv) * NCOLS + int'(iu);
      if (!shadow_written[base])
        add_write(int'(iu), int'(iv), int'($urandom_range(255)));
      if (!shadow_written[base+1])
        add_write(int'(iu) + 1, int'(iv), int'($urandom_range(255)));
      if (!shadow_written[base+NCOLS])
        add_write(int'(iu), int'(iv) + 1, int'($urandom_range(255)));
      if (!shadow_written[base+NCOLS+1])
        add_write(int'(iu) + 1, int'(iv) + 1, int'($urandom_range(255)));
      lt = shadow_frame[base];
      rt = shadow_frame[base+1];
      lb = shadow_frame[base+NCOLS];
      rb = shadow_frame[base+NCOLS+1];
      top = ((fu * rt + (4096 - fu) * lt) >>> 12) & 8'hFF;
      bot = ((fu * rb + (4096 - fu) * lb) >>> 12) & 8'hFF;
      e.value = PIX_W'(((top * (4096 - fv) + bot * fv) >>> 12) & 8'hFF);
      e.in_range = 1'b1;
      n_inside++;
    end
    q.command = CMD_COMPUTE;
    q.col = COL_W'(c);
    q.row = ROW_W'(r);
    q.pixel = PIX_W'($urandom_range(255));
    pending_reqs.push_back(q);
    expected_pixels.push_back(e);
    n_computes++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    remap_regs[idx] = (idx <= REG_CENTER_Y) ? {8'd0, data[23:0]} : data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_regs(input logic [31:0] fx, fy, cx, cy, k1, k2, p1, p2);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_RADIAL_K1, k1);
    write_reg(REG_RADIAL_K2, k2);
    write_reg(REG_TANGENTIAL_P1, p1);
    write_reg(REG_TANGENTIAL_P2, p2);
  endtask

  // Wait until every request is taken and every result checked, then let writes settle.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  // Mostly computes with their sample windows prepared, plus stray writes as noise.
  task automatic random_requests(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        add_write(int'($urandom_range(NCOLS - 1)), int'($urandom_range(NROWS - 1)),
                  int'($urandom_range(255)));
      else
        add_compute(int'($urandom_range(NCOLS - 1)), int'($urandom_range(NROWS - 1)));
    end
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid_i <= 1'b1;
        in_req_i <= pending_reqs.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver readiness, with one long hold-off counted here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (hold_arm && !hold_used) begin
        hold_used <= 1;
        hold_cnt <= 400;
        out_ready_i <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: value %0d in_range %0d", out_rsp_o.value, out_rsp_o.in_range);
        err_count++;
      end else begin
        e = expected_pixels.pop_front();
        n_checked++;
        if (out_rsp_o.value !== e.value) begin
          $error("value: expected %0d, got %0d", e.value, out_rsp_o.value);
          err_count++;
        end
        if (out_rsp_o.in_range !== e.in_range) begin
          $error("in_range: expected %0d, got %0d", e.in_range, out_rsp_o.in_range);
          err_count++;
        end
      end
    end
  end

  initial begin
    #(12 * 800000);
    $display("lens_undistort_bilinear_remap_unit regression: fail");
    $finish;
  end

  initial begin
    remap_regs[REG_FOCAL_X] = {8'd0, RST_FOCAL_X};
    remap_regs[REG_FOCAL_Y] = {8'd0, RST_FOCAL_Y};
    remap_regs[REG_CENTER_X] = {8'd0, RST_CENTER_X};
    remap_regs[REG_CENTER_Y] = {8'd0, RST_CENTER_Y};
    remap_regs[REG_RADIAL_K1] = RST_K1;
    remap_regs[REG_RADIAL_K2] = RST_K2;
    remap_regs[REG_TANGENTIAL_P1] = RST_P1;
    remap_regs[REG_TANGENTIAL_P2] = RST_P2;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: frame corners, pixel extremes, corner and center computes.
    add_write(0, 0, 0);
    add_write(NCOLS - 1, NROWS - 1, 255);
    add_write(NCOLS - 1, 0, 255);
    add_write(0, NROWS - 1, 0);
    add_compute(0, 0);
    add_compute(NCOLS - 1, NROWS - 1);
    add_compute(NCOLS - 1, 0);
    add_compute(0, NROWS - 1);
    add_compute(367, 248);
    add_compute(368, 249);
    add_compute(700, 400);
    add_compute(100, 50);
    drain();

    // Default registers, receiver held off long enough to back up the input.
    hold_arm = 1;
    random_requests(60);
    drain();

    // No lens distortion, sender mostly idle.
    load_regs(24'd2000000, 24'd2000000, 24'd2000000, 24'd1000000, 0, 0, 0, 0);
    sender_idle_pct = 80;
    random_requests(40);
    drain();

    // Coefficient and focal extremes, including a zero focal length.
    load_regs(24'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    sender_idle_pct = 0;
    receiver_stall_pct = 80;
    random_requests(40);
    drain();
    load_regs(24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'd0,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    random_requests(40);
    add_compute(0, 0);
    add_compute(NCOLS - 1, NROWS - 1);
    drain();
    load_regs(24'd4096, 24'd4096, 24'd1000000, 24'd500000, 0, 0, 0, 0);
    random_requests(40);
    drain();

    // Random moderate lenses, both sides idling.
    sender_idle_pct = 31;
    receiver_stall_pct = 31;
    for (int ph = 0; ph < 3; ph++) begin
      load_regs($urandom_range(5000000, 1000000), $urandom_range(5000000, 1000000),
                $urandom_range(3000000, 1000000), $urandom_range(1500000, 500000),
                $signed($urandom_range(200000000)) - 100000000,
                $signed($urandom_range(60000000)) - 30000000,
                $signed($urandom_range(2000000)) - 1000000,
                $signed($urandom_range(2000000)) - 1000000);
      random_requests(25);
      drain();
    end

    $display("Covered %0d frame writes and %0d computes, %0d sampled inside the image;",
             n_writes, n_computes, n_inside);
    $display("%0d results checked over default, flat, extreme and random lens settings.",
             n_checked);
    if (err_count == 0)
      $display("lens_undistort_bilinear_remap_unit regression: pass");
    else
      $display("lens_undistort_bilinear_remap_unit regression: fail");
    $finish;
  end

endmodule

// File: files.f
design/ldu_pkg.sv
design/lens_undistort_bilinear_remap_unit.sv
sim/lens_undistort_bilinear_remap_unit_tb.sv
